### src/gbn_pkg.sv
// Package: shared constants and payload types for the greedy box NMS unit.
`default_nettype none
package gbn_pkg;
  localparam int MaxBoxes  = 64;
  localparam int CoordBits = 16;
  localparam int IdxW      = $clog2(MaxBoxes);
  localparam int CntW      = $clog2(MaxBoxes + 1);
  localparam int AreaW     = 2 * CoordBits;
  localparam int ThrW      = 17;
  localparam logic [ThrW-1:0] ThrReset = 17'd29491;
  localparam logic [1:0] RegIouThr = 2'd0;

  typedef struct packed {
    logic [15:0] box_x1;
    logic [15:0] box_y1;
    logic [15:0] box_x2;
    logic [15:0] box_y2;
    logic [15:0] box_score;
    logic        in_last;
  } gbn_in_t;

  typedef struct packed {
    logic [5:0] kept_index;
    logic       out_last;
    logic       overflow;
  } gbn_out_t;

  typedef struct packed {
    logic [CoordBits-1:0] x1;
    logic [CoordBits-1:0] y1;
    logic [CoordBits-1:0] x2;
    logic [CoordBits-1:0] y2;
  } gbn_box_t;

  // Command from the sequencer to every cell.
  typedef struct packed {
    logic load;
    logic rotate;
    logic clear;
  } gbn_cmd_t;
endpackage
`default_nettype wire

### src/greedy_box_nms_unit.sv
// Top level: greedy box NMS over a rotating ring of box cells.
//
//   channel | direction | handshake        | beat payload
//   in      | input     | in_valid/ready   | gbn_in_t box and in_last
//   out     | output    | out_valid/ready  | gbn_out_t kept index, flags
//   apb     | input     | psel/penable     | iou_threshold at 0x0
//
// Loading accepts one beat per cycle; a beat that finds the store full is
// accepted and dropped. After the closing beat each kept box takes a find
// pass that rotates the ring once to pick the best alive box, a suppress
// pass that runs the ring past the IoU unit and an emit step that hands the
// beat to the output register.
// Reset clears all alive bits and control state. A held result stalls the
// sequencer in the emit state; input is refused until the set is finished.
`default_nettype none
module greedy_box_nms_unit import gbn_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire gbn_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output gbn_out_t     out_data_o,
  input  wire logic    psel,
  input  wire logic    penable,
  input  wire logic    pwrite,
  input  wire logic [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam logic [1:0] StLoad = 2'd0, StFind = 2'd1, StSupp = 2'd2, StEmit = 2'd3;
  localparam int Head = MaxBoxes - 1;

  logic [1:0] st_q, st_d;
  logic [ThrW-1:0] thr_q;
  logic [CntW-1:0] cnt_q, cnt_d, step_q, step_d;
  logic dropped_q, dropped_d, any_q, any_d, surv_q, surv_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic [15:0] best_score_q, best_score_d;
  gbn_box_t best_box_q, best_box_d;
  logic [AreaW-1:0] best_area_q, best_area_d;
  gbn_out_t obuf_q, obuf_d;
  logic obuf_v_q, obuf_v_d;
  gbn_cmd_t cmd;
  logic kill_next;
  logic out_fire, emit_ok, iou_over;
  logic [CoordBits-1:0] cw_h, ch_h;

  // Cell outputs; cell g feeds cell g+1, the head feeds cell 0.
  gbn_box_t box_w [MaxBoxes];
  logic [15:0] score_w [MaxBoxes];
  logic [IdxW-1:0] idx_w [MaxBoxes];
  logic alive_w [MaxBoxes];

  gbn_box_t ring_box;
  logic [15:0] ring_score;
  logic [IdxW-1:0] ring_idx;
  logic ring_alive;

  // APB: one register, always ready.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= ThrReset;
    else if (psel && penable && pwrite && paddr == RegIouThr) thr_q <= pwdata[ThrW-1:0];
  end
  assign prdata = (paddr == RegIouThr) ? 32'(thr_q) : '0;

  // IoU unit looks at the head; its verdict lands in the next cycle, when that
  // entry sits in cell 0 and is about to move into cell 1.
  gbn_iou u_iou (
    .clk_i, .ref_i(best_box_q), .ref_area_i(best_area_q), .cand_i(box_w[Head]),
    .thr_i(thr_q), .over_o(iou_over)
  );

  // Cell 0 takes the input on a load, else the head entry wraps around.
  always_comb begin
    if (cmd.load) begin
      ring_box.x1 = in_data_i.box_x1[CoordBits-1:0];
      ring_box.y1 = in_data_i.box_y1[CoordBits-1:0];
      ring_box.x2 = in_data_i.box_x2[CoordBits-1:0];
      ring_box.y2 = in_data_i.box_y2[CoordBits-1:0];
      ring_score = in_data_i.box_score;
      ring_idx = cnt_q[IdxW-1:0];
      ring_alive = 1'b1;
    end else begin
      ring_box = box_w[Head];
      ring_score = score_w[Head];
      ring_idx = idx_w[Head];
      ring_alive = alive_w[Head];
    end
  end

  for (genvar g = 0; g < MaxBoxes; g++) begin : g_cell
    if (g == 0) begin : g_first
      gbn_cell u_cell (
        .clk_i, .rst_ni, .cmd_i(cmd), .kill_i(1'b0),
        .box_i(ring_box), .score_i(ring_score), .idx_i(ring_idx), .alive_i(ring_alive),
        .box_o(box_w[g]), .score_o(score_w[g]), .idx_o(idx_w[g]), .alive_o(alive_w[g])
      );
    end else begin : g_next
      gbn_cell u_cell (
        .clk_i, .rst_ni, .cmd_i(cmd), .kill_i((g == 1) && kill_next),
        .box_i(box_w[g-1]), .score_i(score_w[g-1]), .idx_i(idx_w[g-1]),
        .alive_i(alive_w[g-1]),
        .box_o(box_w[g]), .score_o(score_w[g]), .idx_o(idx_w[g]), .alive_o(alive_w[g])
      );
    end
  end

  assign cw_h = (box_w[Head].x2 > box_w[Head].x1) ? box_w[Head].x2 - box_w[Head].x1 : '0;
  assign ch_h = (box_w[Head].y2 > box_w[Head].y1) ? box_w[Head].y2 - box_w[Head].y1 : '0;

  assign out_fire = out_valid_o && out_ready_i;
  assign emit_ok = !obuf_v_q || out_fire;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; step_d = step_q; dropped_d = dropped_q; any_d = any_q;
    surv_d = surv_q;
    best_idx_d = best_idx_q; best_score_d = best_score_q; best_box_d = best_box_q;
    best_area_d = best_area_q;
    obuf_d = obuf_q; obuf_v_d = obuf_v_q && !out_fire;
    cmd = '0;
    kill_next = 1'b0;
    in_ready_o = 1'b0;
    case (st_q)
      StLoad: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CntW'(MaxBoxes)) begin
            cmd.load = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end else begin
            // Store full: drop the box, keep the ring still.
            dropped_d = 1'b1;
          end
          if (in_data_i.in_last) begin
            st_d = StFind; step_d = '0; any_d = 1'b0;
          end
        end
      end
      StFind: begin
        // Rotate once around; the head sweeps every cell.
        cmd.rotate = 1'b1;
        if (alive_w[Head] && (!any_q || score_w[Head] > best_score_q ||
            (score_w[Head] == best_score_q && idx_w[Head] < best_idx_q))) begin
          any_d = 1'b1;
          best_idx_d = idx_w[Head];
          best_score_d = score_w[Head];
          best_box_d = box_w[Head];
          best_area_d = AreaW'(cw_h) * AreaW'(ch_h);
        end
        step_d = step_q + CntW'(1);
        if (step_q == CntW'(MaxBoxes - 1)) begin
          step_d = '0;
          surv_d = 1'b0;
          if (any_d) begin
            st_d = StSupp;
          end else begin
            st_d = StLoad; cnt_d = '0; dropped_d = 1'b0;
          end
        end
      end
      StSupp: begin
        // Step 0 primes the IoU unit; steps 1..MaxBoxes judge the entry in
        // cell 0: drop the kept box itself and every box whose IoU with it exceeds the threshold.
        cmd.rotate = 1'b1;
        if (step_q != '0) begin
          kill_next = (idx_w[0] == best_idx_q) || iou_over;
          if (alive_w[0] && !kill_next) surv_d = 1'b1;
        end
        step_d = step_q + CntW'(1);
        if (step_q == CntW'(MaxBoxes)) begin
          step_d = '0;
          st_d = StEmit;
        end
      end
      StEmit: begin
        if (emit_ok) begin
          obuf_d.kept_index = 6'(best_idx_q);
          obuf_d.out_last = !surv_q;
          obuf_d.overflow = dropped_q;
          obuf_v_d = 1'b1;
          any_d = 1'b0;
          if (surv_q) begin
            st_d = StFind;
          end else begin
            // Set done: clear the ring and go back to loading.
            cmd.clear = 1'b1;
            st_d = StLoad; cnt_d = '0; dropped_d = 1'b0;
          end
        end
      end
      default: st_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; cnt_q <= '0; step_q <= '0; dropped_q <= 1'b0; any_q <= 1'b0;
      surv_q <= 1'b0; obuf_v_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; step_q <= step_d; dropped_q <= dropped_d;
      any_q <= any_d; surv_q <= surv_d; obuf_v_q <= obuf_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d; best_score_q <= best_score_d; best_box_q <= best_box_d;
    best_area_q <= best_area_d; obuf_q <= obuf_d;
  end

  assign out_valid_o = obuf_v_q;
  assign out_data_o = obuf_q;

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> st_q == StLoad) else $error("input taken outside load");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBoxes)) else $error("box count beyond capacity");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o)) else $error("result changed");
endmodule
`default_nettype wire

### src/gbn_cell.sv
// One storage cell of the rotating box ring.
`default_nettype none
module gbn_cell import gbn_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire gbn_cmd_t    cmd_i,
  input  wire logic        kill_i,
  input  wire gbn_box_t    box_i,
  input  wire logic [15:0] score_i,
  input  wire logic [IdxW-1:0] idx_i,
  input  wire logic        alive_i,
  output gbn_box_t         box_o,
  output logic [15:0]      score_o,
  output logic [IdxW-1:0]  idx_o,
  output logic             alive_o
);
  gbn_box_t box_q;
  logic [15:0] score_q;
  logic [IdxW-1:0] idx_q;
  logic alive_q, alive_d;

  always_comb begin
    alive_d = alive_q;
    if (cmd_i.clear) alive_d = 1'b0;
    else if (cmd_i.load || cmd_i.rotate) alive_d = alive_i & ~kill_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) alive_q <= 1'b0;
    else alive_q <= alive_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.rotate) begin
      box_q   <= box_i;
      score_q <= score_i;
      idx_q   <= idx_i;
    end
  end

  assign box_o = box_q;
  assign score_o = score_q;
  assign idx_o = idx_q;
  assign alive_o = alive_q;
endmodule
`default_nettype wire

### src/gbn_iou.sv
// Two-stage IoU compare of a reference box against one candidate.
`default_nettype none
module gbn_iou import gbn_pkg::*; (
  input  wire logic          clk_i,
  input  wire gbn_box_t      ref_i,
  input  wire logic [AreaW-1:0] ref_area_i,
  input  wire gbn_box_t      cand_i,
  input  wire logic [ThrW-1:0] thr_i,
  output logic               over_o
);
  logic [CoordBits-1:0] ix1, iy1, ix2, iy2, iw, ih, cw, ch;
  logic [AreaW-1:0] inter_q, carea_q;
  logic [AreaW:0] uni;
  logic [AreaW+16:0] lhs, rhs;

  always_comb begin
    ix1 = (ref_i.x1 > cand_i.x1) ? ref_i.x1 : cand_i.x1;
    iy1 = (ref_i.y1 > cand_i.y1) ? ref_i.y1 : cand_i.y1;
    ix2 = (ref_i.x2 < cand_i.x2) ? ref_i.x2 : cand_i.x2;
    iy2 = (ref_i.y2 < cand_i.y2) ? ref_i.y2 : cand_i.y2;
    iw = (ix2 > ix1) ? ix2 - ix1 : '0;
    ih = (iy2 > iy1) ? iy2 - iy1 : '0;
    cw = (cand_i.x2 > cand_i.x1) ? cand_i.x2 - cand_i.x1 : '0;
    ch = (cand_i.y2 > cand_i.y1) ? cand_i.y2 - cand_i.y1 : '0;
  end

  always_ff @(posedge clk_i) begin
    inter_q <= AreaW'(iw) * AreaW'(ih);
    carea_q <= AreaW'(cw) * AreaW'(ch);
  end

  // Second stage: union and the cross-multiplied threshold test.
  always_comb begin
    uni = {1'b0, ref_area_i} + {1'b0, carea_q} - {1'b0, inter_q};
    lhs = {1'b0, inter_q, 16'h0};
    rhs = (AreaW + 17)'(uni) * (AreaW + 17)'(thr_i);
  end

  assign over_o = lhs > rhs;
endmodule
`default_nettype wire
